// ----- src/deque_with_max_core_macros.svh -----
// assertion macros for the deque with max core
`ifndef DEQUE_WITH_MAX_CORE_MACROS_SVH
`define DEQUE_WITH_MAX_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define DWM_ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: label");
// next-cycle implication, checked out of reset
`define DWM_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: label");
`else
`define DWM_ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define DWM_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- src/dwm_pkg.sv -----
// shared types and constants for the deque with max core
package dwm_pkg;

    typedef logic signed [31:0] word_t;

    localparam word_t EMPTY_MARK = -32'sd1;

    // per-cell operation broadcast along the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ADD_BACK,
        CELL_ADD_FRONT,
        CELL_DEL_BACK,
        CELL_DEL_FRONT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        word_t    data;
    } cell_cmd_t;

    // running scan result handed from cell to cell
    typedef struct packed {
        logic  have;
        word_t max;
        word_t back;
    } scan_t;

endpackage

// ----- src/deque_with_max_core.sv -----
// deque with max: top level with control, cell row and output register
// an accepted item starts a max and back scan that walks the row of DEPTH cells
//   one cell per cycle; no new item is taken until that scan has ended and its
//   result is loaded into the output register
// the next item is taken while a finished result still waits on the output
// reset (async, active low) empties the row and clears control; cell data is not reset
`include "deque_with_max_core_macros.svh"

module deque_with_max_core
    import dwm_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // data_value[31:0]
    input  logic [1:0]   s_tuser,   // mode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // front_value[31:0], back_value[63:32], entry_count[68:64],
    // max_value[100:69], is_empty[101], op_error[103:102]
    output logic [103:0] m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);

    // operation codes on s_tuser
    localparam logic [1:0] MODE_ADD_BACK  = 2'd0;
    localparam logic [1:0] MODE_ADD_FRONT = 2'd1;
    localparam logic [1:0] MODE_DEL_BACK  = 2'd2;
    localparam logic [1:0] MODE_DEL_FRONT = 2'd3;

    // result error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [1:0]     err_reg, err_next;
    logic           out_valid_reg, out_valid_next;
    logic [103:0]   out_data_reg, out_data_next;

    logic           accept;
    logic           is_full;
    logic           is_empty;
    logic           load;
    cell_op_t       op;
    logic [1:0]     op_err;
    logic [CW-1:0]  op_count;
    cell_cmd_t      cmd;
    logic [31:0]    count_wide;

    word_t          cell_value [DEPTH];
    logic [DEPTH-1:0] cell_occ;
    scan_t          cell_scan [DEPTH];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    // decode the operation; errored ones leave the row untouched
    always_comb
    begin
        op       = CELL_HOLD;
        op_err   = ERR_NONE;
        op_count = count_reg;
        case (s_tuser)
            MODE_ADD_BACK:
            begin
                if (is_full)
                begin
                    op_err = ERR_FULL;
                end
                else
                begin
                    op       = CELL_ADD_BACK;
                    op_count = count_reg + CW'(1);
                end
            end
            MODE_ADD_FRONT:
            begin
                if (is_full)
                begin
                    op_err = ERR_FULL;
                end
                else
                begin
                    op       = CELL_ADD_FRONT;
                    op_count = count_reg + CW'(1);
                end
            end
            MODE_DEL_BACK:
            begin
                if (is_empty)
                begin
                    op_err = ERR_EMPTY;
                end
                else
                begin
                    op       = CELL_DEL_BACK;
                    op_count = count_reg - CW'(1);
                end
            end
            MODE_DEL_FRONT:
            begin
                if (is_empty)
                begin
                    op_err = ERR_EMPTY;
                end
                else
                begin
                    op       = CELL_DEL_FRONT;
                    op_count = count_reg - CW'(1);
                end
            end
            default:
            begin
                op = CELL_HOLD;
            end
        endcase
    end

    assign cmd.op   = accept ? op : CELL_HOLD;
    assign cmd.data = s_tdata;

    // row of cells: cell 0 is the front, values stay packed toward it
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t lv;
        logic  lo;
        word_t rv;
        logic  ro;
        scan_t si;

        if (i == 0)
        begin : g_first
            // a push at the front enters here; the scan starts empty
            assign lv = s_tdata;
            assign lo = 1'b1;
            assign si = '{have: 1'b0, max: EMPTY_MARK, back: EMPTY_MARK};
        end
        else
        begin : g_inner_left
            assign lv = cell_value[i-1];
            assign lo = cell_occ[i-1];
            assign si = cell_scan[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign rv = cell_value[i];
            assign ro = 1'b0;
        end
        else
        begin : g_inner_right
            assign rv = cell_value[i+1];
            assign ro = cell_occ[i+1];
        end

        dwm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_value  (lv),
            .left_occ    (lo),
            .right_value (rv),
            .right_occ   (ro),
            .scan_in     (si),
            .scan_out    (cell_scan[i]),
            .value       (cell_value[i]),
            .occupied    (cell_occ[i])
        );
    end

    // the scan has reached the last cell once the scan counter reaches DEPTH;
    // hold there if the previous result has not been taken yet
    assign load = (state_reg == ST_SCAN) && (scan_cnt_reg == CW'(DEPTH))
                  && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                    count_next    = op_count;
                    err_next      = op_err;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg != CW'(DEPTH))
                begin
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign count_wide = 32'(count_reg);

    // result item assembly
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (is_empty)
            begin
                out_data_next = {err_reg, 1'b1, EMPTY_MARK, count_wide[4:0],
                                 EMPTY_MARK, EMPTY_MARK};
            end
            else
            begin
                out_data_next = {err_reg, 1'b0, cell_scan[DEPTH-1].max, count_wide[4:0],
                                 cell_scan[DEPTH-1].back, cell_value[0]};
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            count_reg     <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // front cell occupancy tracks the count
    `DWM_ASSERT_IMPLIES(a_front_occ, clk, rst_n, 1'b1, cell_occ[0] == (count_reg != '0))
    // last cell occupancy tracks a full queue
    `DWM_ASSERT_IMPLIES(a_last_occ, clk, rst_n, 1'b1,
        cell_occ[DEPTH-1] == (count_reg == CW'(DEPTH)))
    // an accepted item always starts a scan
    `DWM_ASSERT_NEXT(a_accept_scan, clk, rst_n, accept, state_reg == ST_SCAN)
    // no reserved error code ever leaves the block
    `DWM_ASSERT_IMPLIES(a_err_code, clk, rst_n, m_tvalid, m_tdata[103:102] != 2'd3)

endmodule

// ----- src/dwm_cell.sv -----
// one storage cell of the deque row with its scan stage
module dwm_cell
    import dwm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  word_t     left_value,
    input  logic      left_occ,
    input  word_t     right_value,
    input  logic      right_occ,
    input  scan_t     scan_in,
    output scan_t     scan_out,
    output word_t     value,
    output logic      occupied
);

    word_t value_reg, value_next;
    logic  occ_reg, occ_next;
    word_t max_reg, max_next;
    word_t back_reg, back_next;
    logic  have_reg, have_next;

    always_comb
    begin
        value_next = value_reg;
        occ_next   = occ_reg;
        case (cmd.op)
            CELL_ADD_BACK:
            begin
                if (!occ_reg && left_occ)
                begin
                    value_next = cmd.data;
                    occ_next   = 1'b1;
                end
            end
            CELL_ADD_FRONT:
            begin
                value_next = left_value;
                occ_next   = left_occ;
            end
            CELL_DEL_BACK:
            begin
                if (occ_reg && !right_occ)
                begin
                    occ_next = 1'b0;
                end
            end
            CELL_DEL_FRONT:
            begin
                value_next = right_value;
                occ_next   = right_occ;
            end
            default:
            begin
                value_next = value_reg;
                occ_next   = occ_reg;
            end
        endcase
    end

    // fold this cell into the running max and back value
    always_comb
    begin
        have_next = scan_in.have | occ_reg;
        if (occ_reg && (!scan_in.have || (value_reg > scan_in.max)))
        begin
            max_next = value_reg;
        end
        else
        begin
            max_next = scan_in.max;
        end
        if (occ_reg && !right_occ)
        begin
            back_next = value_reg;
        end
        else
        begin
            back_next = scan_in.back;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            have_reg <= 1'b0;
        end
        else
        begin
            occ_reg  <= occ_next;
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        max_reg   <= max_next;
        back_reg  <= back_next;
    end

    assign value         = value_reg;
    assign occupied      = occ_reg;
    assign scan_out.have = have_reg;
    assign scan_out.max  = max_reg;
    assign scan_out.back = back_reg;

endmodule
